// ----- sv/chained_hash_table_engine_assert.svh -----
// Assertion macros for the chained hash table engine checker.
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CHT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ----- sv/cht_pkg.sv -----
// Package of shared types and codes for the chained hash table engine.
package cht_pkg;
   localparam int IN_WORDS = 4;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   // Operation the controller asks of the datapath in a cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_INIT_WR,
      OP_INS_RD,
      OP_INS_WR,
      OP_HEAD_RD,
      OP_ENT_RD,
      OP_CHECK,
      OP_UNLINK,
      OP_FREE_PUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic init_last;
      logic is_insert;
      logic is_walk;
      logic pool_empty;
      logic cur_nil;
      logic match;
      logic step_limit;
   } stat_type;
endpackage

// ----- sv/chained_hash_table_engine.sv -----
// Top level of the chained hash table engine.
//  channel | ports                          | handshake
//  req     | cmd, key words, meta, value_in | req_valid / req_ready
//  rsp     | value_out, status              | rsp_valid / rsp_ready
// From acceptance to the result: decode, then per chain entry visited a link
// check, entry read and compare; a match adds unlink and free (idle for a
// lookup); insert adds read and write; a refused insert or unused command goes
// from decode to the result. After reset an init pass builds the free list;
// no item is taken meanwhile. A stalled result holds the block until it is taken.
module chained_hash_table_engine #(
   parameter int ENTRIES = 64,
   parameter int KEY_WORDS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_key_word_0,
   input  logic [31:0] req_key_word_1,
   input  logic [31:0] req_key_word_2,
   input  logic [31:0] req_key_word_3,
   input  logic [1:0]  req_key_full_words,
   input  logic [5:0]  req_key_bits_left,
   input  logic [31:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value_out,
   output logic [1:0]  rsp_status
);
   cht_pkg::ctl_type  ctl;
   cht_pkg::stat_type stat;

   cht_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .ctl, .sts_code(rsp_status)
   );

   cht_datapath #(.ENTRIES(ENTRIES), .KEY_WORDS(KEY_WORDS)) u_dp (
      .clock, .reset, .req_cmd, .req_key_word_0, .req_key_word_1,
      .req_key_word_2, .req_key_word_3, .req_key_full_words,
      .req_key_bits_left, .req_value_in, .ctl,
      .stat, .rsp_value_out
   );
endmodule

// ----- sv/cht_ctrl.sv -----
// Controller state machine for the chained hash table engine.
module cht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cht_pkg::stat_type stat,
   output cht_pkg::ctl_type  ctl,
   output logic [1:0]        sts_code
);
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DECODE, S_INS_RD, S_INS_WR, S_HEAD, S_ENT, S_CHECK,
      S_UNLINK, S_FREE, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] sts_ff, sts_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign sts_code  = sts_ff;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      sts_in = sts_ff;
      ctl.op = cht_pkg::OP_NONE;
      case (state_ff)
         S_INIT: begin
            ctl.op = cht_pkg::OP_INIT_WR;
            if (stat.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.op = cht_pkg::OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_insert) begin
               if (stat.pool_empty) begin
                  sts_in = cht_pkg::ST_FULL;
                  state_in = S_RESP;
               end else begin
                  ctl.op = cht_pkg::OP_INS_RD;
                  state_in = S_INS_RD;
               end
            end else if (stat.is_walk) begin
               ctl.op = cht_pkg::OP_HEAD_RD;
               state_in = S_HEAD;
            end else begin
               sts_in = cht_pkg::ST_MISS;
               state_in = S_RESP;
            end
         end
         S_INS_RD: state_in = S_INS_WR;
         S_INS_WR: begin
            ctl.op = cht_pkg::OP_INS_WR;
            sts_in = cht_pkg::ST_DONE;
            state_in = S_RESP;
         end
         S_HEAD: begin
            if (stat.cur_nil) begin
               sts_in = cht_pkg::ST_MISS;
               state_in = S_RESP;
            end else begin
               ctl.op = cht_pkg::OP_ENT_RD;
               state_in = S_ENT;
            end
         end
         S_ENT: state_in = S_CHECK;
         S_CHECK: begin
            ctl.op = cht_pkg::OP_CHECK;
            if (stat.match) begin
               sts_in = cht_pkg::ST_DONE;
               state_in = S_UNLINK;
            end else begin
               if (stat.step_limit) begin
                  sts_in = cht_pkg::ST_MISS;
                  state_in = S_RESP;
               end else state_in = S_HEAD;
            end
         end
         S_UNLINK: begin
            ctl.op = cht_pkg::OP_UNLINK;
            state_in = S_FREE;
         end
         S_FREE: begin
            ctl.op = cht_pkg::OP_FREE_PUSH;
            state_in = S_RESP;
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sts_ff <= cht_pkg::ST_DONE;
      end else begin
         state_ff <= state_in;
         sts_ff <= sts_in;
      end
   end
endmodule

// ----- sv/cht_datapath.sv -----
// Datapath of the chained hash table engine: entry memories, links, compare.
module cht_datapath #(
   parameter int ENTRIES = 64,
   parameter int KEY_WORDS = 4
) (
   input  logic              clock,
   input  logic [1:0]        req_cmd,
   input  logic [31:0]       req_key_word_0,
   input  logic [31:0]       req_key_word_1,
   input  logic [31:0]       req_key_word_2,
   input  logic [31:0]       req_key_word_3,
   input  logic [1:0]        req_key_full_words,
   input  logic [5:0]        req_key_bits_left,
   input  logic [31:0]       req_value_in,
   input  logic              reset,
   input  cht_pkg::ctl_type  ctl,
   output cht_pkg::stat_type stat,
   output logic [31:0]       rsp_value_out
);
   localparam int AW = $clog2(ENTRIES);
   localparam int PW = AW + 1;
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);
   localparam int USE = (KEY_WORDS < cht_pkg::IN_WORDS) ? KEY_WORDS : cht_pkg::IN_WORDS;

   // Memories
   logic [PW-1:0] head_mem [ENTRIES];
   logic [PW-1:0] next_mem [ENTRIES];
   logic [31:0]   key_mem  [ENTRIES][USE];
   logic [7:0]    meta_mem [ENTRIES];
   logic [31:0]   val_mem  [ENTRIES];

   logic [1:0]       cmd_ff;
   logic [31:0]      w_ff [cht_pkg::IN_WORDS];
   logic [7:0]       meta_ff;
   logic [31:0]      val_ff;
   logic [AW-1:0]    hash_ff;
   logic [PW-1:0]    free_ff, cur_ff, prev_ff, nxt_ff, head_rd_ff;
   logic [AW-1:0]    init_ff;
   logic [PW-1:0]    steps_ff;
   logic [7:0]       e_meta_ff;
   logic [31:0]      e_key_ff [USE];
   logic [31:0]      e_val_ff;
   logic [31:0]      out_ff;
   logic [31:0]      h_in;
   logic             match;
   logic             head_phase_ff;
   logic [AW-1:0]    ent_addr;

   // Hash of completed words of the request
   always_comb begin
      logic [31:0] w [cht_pkg::IN_WORDS];
      w[0] = req_key_word_0; w[1] = req_key_word_1;
      w[2] = req_key_word_2; w[3] = req_key_word_3;
      h_in = '0;
      for (int i = 0; i < USE; i++)
         if (i < int'(req_key_full_words)) h_in = h_in ^ w[i];
   end

   // Key compare against the fetched entry
   always_comb begin
      match = (e_meta_ff == meta_ff);
      for (int i = 0; i < USE; i++)
         if (i <= int'(meta_ff[7:6]) && e_key_ff[i] != w_ff[i]) match = 1'b0;
   end

   // Entry to fetch: chain head on the first visit, else the current link
   assign ent_addr = head_phase_ff ? head_rd_ff[AW-1:0] : cur_ff[AW-1:0];

   assign stat.init_last  = (init_ff == AW'(ENTRIES - 1));
   assign stat.is_insert  = (cmd_ff == cht_pkg::CMD_INSERT);
   assign stat.is_walk    = (cmd_ff == cht_pkg::CMD_LOOKUP) || (cmd_ff == cht_pkg::CMD_REMOVE);
   assign stat.pool_empty = (free_ff == NIL);
   assign stat.cur_nil    = head_phase_ff ? (head_rd_ff == NIL) : (cur_ff == NIL);
   assign stat.match      = match;
   assign stat.step_limit = (steps_ff == PW'(ENTRIES - 1));
   assign rsp_value_out   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         free_ff <= '0;
         head_phase_ff <= 1'b0;
      end else begin
         case (ctl.op)
            cht_pkg::OP_INIT_WR: begin
               head_mem[init_ff] <= NIL;
               next_mem[init_ff] <= (init_ff == AW'(ENTRIES - 1)) ? NIL : PW'(init_ff) + 1'b1;
               init_ff <= init_ff + 1'b1;
            end
            cht_pkg::OP_CAPTURE: begin
               cmd_ff <= req_cmd;
               w_ff[0] <= req_key_word_0; w_ff[1] <= req_key_word_1;
               w_ff[2] <= req_key_word_2; w_ff[3] <= req_key_word_3;
               meta_ff <= {req_key_full_words, req_key_bits_left};
               val_ff <= req_value_in;
               hash_ff <= h_in[AW-1:0] & AW'(ENTRIES - 1);
               prev_ff <= NIL;
               steps_ff <= '0;
               out_ff <= '0;
               head_phase_ff <= 1'b1;
            end
            cht_pkg::OP_INS_RD: begin
               nxt_ff <= next_mem[free_ff[AW-1:0]];
               head_rd_ff <= head_mem[hash_ff];
            end
            cht_pkg::OP_INS_WR: begin
               for (int i = 0; i < USE; i++) key_mem[free_ff[AW-1:0]][i] <= w_ff[i];
               meta_mem[free_ff[AW-1:0]] <= meta_ff;
               val_mem[free_ff[AW-1:0]] <= val_ff;
               next_mem[free_ff[AW-1:0]] <= head_rd_ff;
               head_mem[hash_ff] <= free_ff;
               free_ff <= nxt_ff;
            end
            cht_pkg::OP_HEAD_RD: head_rd_ff <= head_mem[hash_ff];
            cht_pkg::OP_ENT_RD: begin
               if (head_phase_ff) cur_ff <= head_rd_ff;
               head_phase_ff <= 1'b0;
               for (int i = 0; i < USE; i++)
                  e_key_ff[i] <= key_mem[ent_addr][i];
               e_meta_ff <= meta_mem[ent_addr];
               e_val_ff <= val_mem[ent_addr];
               nxt_ff <= next_mem[ent_addr];
            end
            cht_pkg::OP_CHECK: begin
               if (match) out_ff <= e_val_ff;
               else begin
                  prev_ff <= cur_ff;
                  cur_ff <= nxt_ff;
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            cht_pkg::OP_UNLINK: begin
               if (cmd_ff == cht_pkg::CMD_REMOVE) begin
                  if (prev_ff != NIL) next_mem[prev_ff[AW-1:0]] <= nxt_ff;
                  else head_mem[hash_ff] <= nxt_ff;
               end
            end
            cht_pkg::OP_FREE_PUSH: begin
               if (cmd_ff == cht_pkg::CMD_REMOVE) begin
                  next_mem[cur_ff[AW-1:0]] <= free_ff;
                  free_ff <= cur_ff;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- sv/cht_checker.sv -----
// Port-level checker for the chained hash table engine, with its bind.
`include "chained_hash_table_engine_assert.svh"
module cht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value_out,
   input logic [1:0]  rsp_status
);
   // One item at a time: no acceptance while a result is pending
   `CHT_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // Refused or missed items carry a zero value
   `CHT_ASSERT_IMP(a_zero_val, clock, reset,
      rsp_valid && rsp_status != cht_pkg::ST_DONE, rsp_value_out == 32'd0)
   // An accepted item never answers in the next cycle
   `CHT_ASSERT_NEXT(a_latency, clock, reset, req_valid && req_ready, !rsp_valid)
   // A held result stays valid with its status unchanged
   `CHT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_value_out, .rsp_status
);

// ----- sim/chained_hash_table_engine_checker.sv -----
// Checker for the chained hash table engine: watches both channels, predicts and compares.
module chained_hash_table_engine_checker #(
   parameter int ENTRIES = 64,
   parameter int KEY_WORDS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_key_word_0,
   input  logic [31:0] req_key_word_1,
   input  logic [31:0] req_key_word_2,
   input  logic [31:0] req_key_word_3,
   input  logic [1:0]  req_key_full_words,
   input  logic [5:0]  req_key_bits_left,
   input  logic [31:0] req_value_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_value_out,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending_count,
   output int          found_count,
   output int          full_count,
   output int          miss_count
);
   localparam int NIL = ENTRIES;
   localparam int USE_WORDS = (KEY_WORDS < cht_pkg::IN_WORDS) ? KEY_WORDS : cht_pkg::IN_WORDS;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } lookup_result_type;

   // Shadow table
   int          shadow_head [ENTRIES];
   int          shadow_next [ENTRIES];
   logic [31:0] shadow_words [ENTRIES][cht_pkg::IN_WORDS];
   logic [7:0]  shadow_meta [ENTRIES];
   logic [31:0] shadow_value [ENTRIES];
   int          shadow_free;

   lookup_result_type expected_results[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Apply one accepted item to the shadow table and return its result
   function automatic lookup_result_type apply_table_op(input logic [1:0] cmd,
         input logic [31:0] w [cht_pkg::IN_WORDS], input logic [1:0] full,
         input logic [5:0] left, input logic [31:0] val);
      lookup_result_type r;
      logic [31:0] h;
      logic [7:0] meta;
      int e, cur, prev, steps;
      bit hit;
      r.value = '0;
      r.status = cht_pkg::ST_MISS;
      meta = {full, left};
      h = '0;
      for (int i = 0; i < full && i < USE_WORDS; i++) h ^= w[i];
      h &= ENTRIES - 1;
      if (cmd == cht_pkg::CMD_INSERT) begin
         e = shadow_free;
         if (e >= NIL) begin
            r.status = cht_pkg::ST_FULL;
            return r;
         end
         shadow_free = shadow_next[e];
         for (int i = 0; i < cht_pkg::IN_WORDS; i++) shadow_words[e][i] = w[i];
         shadow_meta[e] = meta;
         shadow_value[e] = val;
         shadow_next[e] = shadow_head[h];
         shadow_head[h] = e;
         r.status = cht_pkg::ST_DONE;
         return r;
      end
      if (cmd != cht_pkg::CMD_LOOKUP && cmd != cht_pkg::CMD_REMOVE) return r;
      prev = NIL;
      cur = shadow_head[h];
      for (steps = 0; cur < NIL && steps < ENTRIES; steps++) begin
         hit = (shadow_meta[cur] == meta);
         for (int i = 0; i <= full && i < USE_WORDS; i++)
            if (shadow_words[cur][i] != w[i]) hit = 0;
         if (hit) begin
            r.value = shadow_value[cur];
            r.status = cht_pkg::ST_DONE;
            if (cmd == cht_pkg::CMD_REMOVE) begin
               if (prev < NIL) shadow_next[prev] = shadow_next[cur];
               else shadow_head[h] = shadow_next[cur];
               shadow_next[cur] = shadow_free;
               shadow_free = cur;
            end
            return r;
         end
         prev = cur;
         cur = shadow_next[cur];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      logic [31:0] w [cht_pkg::IN_WORDS];
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            shadow_head[i] = NIL;
            shadow_next[i] = i + 1;
         end
         shadow_next[ENTRIES-1] = NIL;
         shadow_free = 0;
         expected_results.delete();
         fail_count = 0;
         found_count = 0;
         full_count = 0;
         miss_count = 0;
      end else begin
         // Result side
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_value_out, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value_out !== want.value)
                  report_mismatch("value_out", rsp_value_out, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (want.status == cht_pkg::ST_FULL) full_count++;
               else if (want.status == cht_pkg::ST_MISS) miss_count++;
               else if (want.value != 0) found_count++;
            end
         end
         // Request side
         if (req_valid && req_ready) begin
            w[0] = req_key_word_0;
            w[1] = req_key_word_1;
            w[2] = req_key_word_2;
            w[3] = req_key_word_3;
            expected_results.push_back(apply_table_op(req_cmd, w, req_key_full_words,
                                       req_key_bits_left, req_value_in));
         end
      end
      pending_count = expected_results.size();
   end
endmodule

// ----- sim/chained_hash_table_engine_tb.sv -----
// Testbench top for the chained hash table engine: stimulus, stalls and verdict.
module chained_hash_table_engine_tb;
   localparam int ENTRIES = 64;
   localparam int RANDOM_ITEMS = 369;
   localparam int CYCLE_LIMIT = 400000;
   localparam int KEY_POOL = 24;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_cmd = cht_pkg::CMD_INSERT;
   logic [31:0] req_key_word_0 = '0;
   logic [31:0] req_key_word_1 = '0;
   logic [31:0] req_key_word_2 = '0;
   logic [31:0] req_key_word_3 = '0;
   logic [1:0]  req_key_full_words = '0;
   logic [5:0]  req_key_bits_left = '0;
   logic [31:0] req_value_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_value_out;
   logic [1:0]  rsp_status;

   int fail_count, pending_count, found_count, full_count, miss_count;
   int send_idle_pct = 13;
   int recv_idle_pct = 55;
   bit hold_off = 0;
   int cycle_count = 0;

   // Keys that random items draw from, so lookups and removes can hit
   logic [31:0] pool_words [KEY_POOL][cht_pkg::IN_WORDS];
   logic [1:0]  pool_full [KEY_POOL];
   logic [5:0]  pool_left [KEY_POOL];

   always #5 clock = ~clock;

   chained_hash_table_engine #(.ENTRIES(ENTRIES), .KEY_WORDS(4)) u_top (.*);

   chained_hash_table_engine_checker #(.ENTRIES(ENTRIES), .KEY_WORDS(4)) u_checker (.*);

   // Receiver readiness, redrawn each falling edge
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one item at a falling edge and hold it until accepted; valid drops
   // only while the sender idles, so back-to-back items keep it high
   task automatic send_item(input logic [1:0] cmd, input logic [31:0] w0,
         input logic [31:0] w1, input logic [31:0] w2, input logic [31:0] w3,
         input logic [1:0] full, input logic [5:0] left, input logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_key_word_0 <= w0;
      req_key_word_1 <= w1;
      req_key_word_2 <= w2;
      req_key_word_3 <= w3;
      req_key_full_words <= full;
      req_key_bits_left <= left;
      req_value_in <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pool_item(input logic [1:0] cmd, input int k);
      send_item(cmd, pool_words[k][0], pool_words[k][1], pool_words[k][2],
                pool_words[k][3], pool_full[k], pool_left[k], $urandom);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      int k;
      int r;
      for (int i = 0; i < KEY_POOL; i++) begin
         for (int j = 0; j < cht_pkg::IN_WORDS; j++)
            pool_words[i][j] = (i < 4) ? 32'(i * 64) : $urandom;
         pool_full[i] = 2'($urandom_range(3));
         pool_left[i] = 6'($urandom_range(63));
      end
      repeat (6) @(negedge clock);
      reset <= 0;

      // Directed part: extremes, each command, miss, unused command
      send_item(cht_pkg::CMD_LOOKUP, '0, '0, '0, '0, 2'd0, 6'd0, '0);
      send_item(cht_pkg::CMD_INSERT, '0, '0, '0, '0, 2'd0, 6'd0, 32'hFFFF_FFFF);
      send_item(cht_pkg::CMD_INSERT, '1, '1, '1, '1, 2'd3, 6'd63, 32'h1234_5678);
      send_item(cht_pkg::CMD_INSERT, '1, '1, '1, '0, 2'd3, 6'd63, 32'hA5A5_A5A5);
      send_item(cht_pkg::CMD_LOOKUP, '1, '1, '1, '1, 2'd3, 6'd63, '0);
      send_item(cht_pkg::CMD_LOOKUP, '1, '1, '1, '0, 2'd3, 6'd63, '0);
      send_item(cht_pkg::CMD_LOOKUP, '1, '1, '1, '1, 2'd3, 6'd32, '0);
      send_item(cht_pkg::CMD_LOOKUP, '0, '1, '0, '0, 2'd0, 6'd0, '0);
      send_item(cht_pkg::CMD_LOOKUP, '0, '0, '1, '0, 2'd0, 6'd0, '0);
      send_item(cht_pkg::CMD_UNUSED, '1, '1, '1, '1, 2'd3, 6'd63, '1);
      send_item(cht_pkg::CMD_REMOVE, '1, '1, '1, '1, 2'd3, 6'd63, '0);
      send_item(cht_pkg::CMD_REMOVE, '1, '1, '1, '1, 2'd3, 6'd63, '0);
      send_item(cht_pkg::CMD_LOOKUP, '1, '1, '1, '0, 2'd3, 6'd63, '0);
      send_item(cht_pkg::CMD_REMOVE, '0, '0, '0, '0, 2'd0, 6'd0, '0);
      // Same bucket, duplicates, then a full pool
      for (int i = 0; i < ENTRIES + 2; i++)
         send_pool_item(cht_pkg::CMD_INSERT, i % 4);
      send_pool_item(cht_pkg::CMD_REMOVE, 2);
      send_pool_item(cht_pkg::CMD_LOOKUP, 1);
      drain();

      // Random part in three idling phases; the first one includes a long hold-off
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 55 : 0;
         recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 13 : 0;
         if (phase == 0) fork
            begin
               hold_off = 1;
               repeat (300) @(negedge clock);
               hold_off = 0;
            end
         join_none
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            k = $urandom_range(KEY_POOL - 1);
            r = $urandom_range(99);
            if (r < 8)
               send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                         2'($urandom_range(3)), 6'($urandom_range(63)), $urandom);
            else if (r < 45) send_pool_item(cht_pkg::CMD_INSERT, k);
            else if (r < 70) send_pool_item(cht_pkg::CMD_LOOKUP, k);
            else send_pool_item(cht_pkg::CMD_REMOVE, k);
         end
         drain();
      end

      $display("Covered inserts, lookups, removes, unused command, full pool, long stall");
      $display("Results: %0d found, %0d pool full, %0d not found",
               found_count, full_count, miss_count);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
